### src/quadratic_root_solver_assert.svh
// assertion macros used by the solver rtl
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define QRS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("quadratic root solver assertion failed");

// same-cycle implication
`define QRS_IMPLIES(lbl, ante, cons) `QRS_ASSERT(lbl, (ante) |-> (cons))

`endif

### src/qrs_pkg.sv
package qrs_pkg;

  localparam int OUT_FRAC = 16;
  localparam int OUT_W    = 32;

  typedef enum logic [1:0] {
    KIND_TWO     = 2'd0,
    KIND_ONE     = 2'd1,
    KIND_CPLX    = 2'd2,
    KIND_INVALID = 2'd3
  } root_kind_e;

  typedef struct packed {
    logic       valid;
    root_kind_e kind;
  } ctrl_t;

endpackage

### src/qrs_disc.sv
module qrs_disc #(
  parameter int CW = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic signed [CW-1:0]  coef_a_i,
  input  logic signed [CW-1:0]  coef_b_i,
  input  logic signed [CW-1:0]  coef_c_i,
  output qrs_pkg::ctrl_t        ctrl_o,
  output logic [2*CW:0]         disc_o,
  output logic signed [CW-1:0]  a_o,
  output logic signed [CW-1:0]  b_o
);

  localparam int PW = 2 * CW;
  localparam int DW = PW + 1;

  // stage 1: input registers
  logic                 v1_q;
  logic signed [CW-1:0] a1_q, b1_q, c1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q <= coef_a_i;
    b1_q <= coef_b_i;
    c1_q <= coef_c_i;
  end

  // stage 2: products of magnitudes
  logic [CW-1:0] ma, mb, mc;
  logic [PW-1:0] bb_d, ac_d;
  logic          acneg_d;

  always_comb begin
    ma      = a1_q[CW-1] ? CW'(-a1_q) : CW'(a1_q);
    mb      = b1_q[CW-1] ? CW'(-b1_q) : CW'(b1_q);
    mc      = c1_q[CW-1] ? CW'(-c1_q) : CW'(c1_q);
    bb_d    = PW'(mb) * PW'(mb);
    ac_d    = PW'(ma) * PW'(mc);
    acneg_d = (c1_q != '0) && (a1_q[CW-1] != c1_q[CW-1]);
  end

  logic                 v2_q, acneg_q, azero_q;
  logic [PW-1:0]        bb_q, ac_q;
  logic signed [CW-1:0] a2_q, b2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bb_q    <= bb_d;
    ac_q    <= ac_d;
    acneg_q <= acneg_d;
    azero_q <= (a1_q == '0);
    a2_q    <= a1_q;
    b2_q    <= b1_q;
  end

  // stage 3: discriminant magnitude and sign
  logic [PW+1:0]       bbx, ac4;
  logic [DW-1:0]       d_d;
  qrs_pkg::root_kind_e kind_d;

  always_comb begin
    bbx = {2'b00, bb_q};
    ac4 = {ac_q, 2'b00};
    if (acneg_q) begin
      d_d    = DW'(bbx + ac4);
      kind_d = qrs_pkg::KIND_TWO;
    end else if (bbx >= ac4) begin
      d_d    = DW'(bbx - ac4);
      kind_d = (bbx == ac4) ? qrs_pkg::KIND_ONE : qrs_pkg::KIND_TWO;
    end else begin
      d_d    = DW'(ac4 - bbx);
      kind_d = qrs_pkg::KIND_CPLX;
    end
    if (azero_q) begin
      kind_d = qrs_pkg::KIND_INVALID;
    end
  end

  qrs_pkg::ctrl_t ctrl_q;
  logic [DW-1:0]  d_q;
  logic signed [CW-1:0] a3_q, b3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q.valid <= v2_q;
      ctrl_q.kind  <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q  <= d_d;
    a3_q <= a2_q;
    b3_q <= b2_q;
  end

  assign ctrl_o = ctrl_q;
  assign disc_o = d_q;
  assign a_o    = a3_q;
  assign b_o    = b3_q;

endmodule

### src/qrs_sqrt.sv
module qrs_sqrt #(
  parameter int CW = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  qrs_pkg::ctrl_t       ctrl_i,
  input  logic [2*CW:0]        disc_i,
  input  logic signed [CW-1:0] a_i,
  input  logic signed [CW-1:0] b_i,
  output qrs_pkg::ctrl_t       ctrl_o,
  output logic [CW:0]          root_o,
  output logic signed [CW-1:0] a_o,
  output logic signed [CW-1:0] b_o
);

  localparam int SW = CW + 1;
  localparam int RW = SW + 3;
  localparam int XW = 2 * SW;

  // one root bit per stage, two radicand bits consumed per stage
  logic [RW-1:0]        rem_q  [SW];
  logic [SW-1:0]        root_q [SW];
  logic [XW-1:0]        dsh_q  [SW];
  logic signed [CW-1:0] a_q    [SW];
  logic signed [CW-1:0] b_q    [SW];
  qrs_pkg::ctrl_t       ctrl_q [SW];

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic [RW-1:0]        rem_in;
    logic [SW-1:0]        root_in;
    logic [XW-1:0]        d_in;
    logic signed [CW-1:0] a_in, b_in;
    qrs_pkg::ctrl_t       ctrl_in;
    logic [RW-1:0]        nxt, trial, rem_d;
    logic [SW-1:0]        root_d;
    logic                 ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign d_in    = {1'b0, disc_i};
      assign a_in    = a_i;
      assign b_in    = b_i;
      assign ctrl_in = ctrl_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign d_in    = dsh_q[k-1];
      assign a_in    = a_q[k-1];
      assign b_in    = b_q[k-1];
      assign ctrl_in = ctrl_q[k-1];
    end

    always_comb begin
      nxt    = {rem_in[RW-3:0], d_in[XW-1 -: 2]};
      trial  = {1'b0, root_in, 2'b01};
      ge     = (nxt >= trial);
      rem_d  = ge ? (nxt - trial) : nxt;
      root_d = {root_in[SW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctrl_q[k] <= '0;
      end else begin
        ctrl_q[k] <= ctrl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= rem_d;
      root_q[k] <= root_d;
      dsh_q[k]  <= {d_in[XW-3:0], 2'b00};
      a_q[k]    <= a_in;
      b_q[k]    <= b_in;
    end
  end

  assign ctrl_o = ctrl_q[SW-1];
  assign root_o = root_q[SW-1];
  assign a_o    = a_q[SW-1];
  assign b_o    = b_q[SW-1];

endmodule

### src/qrs_div.sv
module qrs_div #(
  parameter int CW = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  qrs_pkg::ctrl_t          ctrl_i,
  input  logic signed [CW+2:0]    num1_i,
  input  logic signed [CW+2:0]    num2_i,
  input  logic signed [CW:0]      den_i,
  output qrs_pkg::ctrl_t          ctrl_o,
  output logic [CW+3+qrs_pkg::OUT_FRAC-1:0] quo1_o,
  output logic [CW+3+qrs_pkg::OUT_FRAC-1:0] quo2_o,
  output logic                    neg1_o,
  output logic                    neg2_o
);

  localparam int NW = CW + 3;
  localparam int QW = NW + qrs_pkg::OUT_FRAC;
  localparam int VW = CW + 1;
  localparam int RW = CW + 2;

  // prep stage: magnitudes and result signs
  qrs_pkg::ctrl_t pc_q;
  logic [QW-1:0]  pq1_q, pq2_q;
  logic [VW-1:0]  pdv_q;
  logic [1:0]     pneg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pq1_q  <= {(num1_i[NW-1] ? NW'(-num1_i) : NW'(num1_i)), {qrs_pkg::OUT_FRAC{1'b0}}};
    pq2_q  <= {(num2_i[NW-1] ? NW'(-num2_i) : NW'(num2_i)), {qrs_pkg::OUT_FRAC{1'b0}}};
    pdv_q  <= den_i[VW-1] ? VW'(-den_i) : VW'(den_i);
    pneg_q <= {num2_i[NW-1] ^ den_i[VW-1], num1_i[NW-1] ^ den_i[VW-1]};
  end

  // restoring division, one quotient bit per stage; dividend shifts out
  // of the top of dq while quotient bits shift in at the bottom
  logic [RW-1:0]  rem1_q [QW];
  logic [RW-1:0]  rem2_q [QW];
  logic [QW-1:0]  dq1_q  [QW];
  logic [QW-1:0]  dq2_q  [QW];
  logic [VW-1:0]  dv_q   [QW];
  logic [1:0]     neg_q  [QW];
  qrs_pkg::ctrl_t ctrl_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [RW-1:0]  r1_in, r2_in, n1, n2, dvx, r1_d, r2_d;
    logic [QW-1:0]  q1_in, q2_in;
    logic [VW-1:0]  dv_in;
    logic [1:0]     neg_in;
    qrs_pkg::ctrl_t ctrl_in;
    logic           ge1, ge2;

    if (k == 0) begin : g_first
      assign r1_in   = '0;
      assign r2_in   = '0;
      assign q1_in   = pq1_q;
      assign q2_in   = pq2_q;
      assign dv_in   = pdv_q;
      assign neg_in  = pneg_q;
      assign ctrl_in = pc_q;
    end else begin : g_next
      assign r1_in   = rem1_q[k-1];
      assign r2_in   = rem2_q[k-1];
      assign q1_in   = dq1_q[k-1];
      assign q2_in   = dq2_q[k-1];
      assign dv_in   = dv_q[k-1];
      assign neg_in  = neg_q[k-1];
      assign ctrl_in = ctrl_q[k-1];
    end

    always_comb begin
      dvx  = {1'b0, dv_in};
      n1   = {r1_in[RW-2:0], q1_in[QW-1]};
      n2   = {r2_in[RW-2:0], q2_in[QW-1]};
      ge1  = (n1 >= dvx);
      ge2  = (n2 >= dvx);
      r1_d = ge1 ? (n1 - dvx) : n1;
      r2_d = ge2 ? (n2 - dvx) : n2;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctrl_q[k] <= '0;
      end else begin
        ctrl_q[k] <= ctrl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem1_q[k] <= r1_d;
      rem2_q[k] <= r2_d;
      dq1_q[k]  <= {q1_in[QW-2:0], ge1};
      dq2_q[k]  <= {q2_in[QW-2:0], ge2};
      dv_q[k]   <= dv_in;
      neg_q[k]  <= neg_in;
    end
  end

  assign ctrl_o = ctrl_q[QW-1];
  assign quo1_o = dq1_q[QW-1];
  assign quo2_o = dq2_q[QW-1];
  assign neg1_o = neg_q[QW-1][0];
  assign neg2_o = neg_q[QW-1][1];

endmodule

### src/quadratic_root_solver.sv
// quadratic root solver: roots of a*x^2 + b*x + c with signed fixed-point
// coefficients, results in signed Q16.16.
// input: drive coef_a_i, coef_b_i, coef_c_i and pulse start_i; a transaction
//   is taken on each rising edge with start_i high and busy_o low. busy_o
//   stays low, so a new coefficient set may enter on every cycle.
// output: result_valid_o is high for exactly one cycle per transaction, with
//   root_kind_o, first_value_o, second_value_o and saturated_o alongside.
//   results leave in the order their transactions entered.
// pipeline: the discriminant stages (input, product and discriminant
//   registers), COEF_WIDTH+1 square root stages, one numerator stage, one
//   divider prep stage, COEF_WIDTH+19 divider stages and an output register.
// throughput: one transaction per cycle; every stage moves each cycle.
// the receiver has no way to stall, so nothing is held back or dropped.
// reset clears all valid bits in the pipeline; data in flight is discarded.
// a zero a yields kind invalid with zero values; clamped values set
// saturated_o.
`include "quadratic_root_solver_assert.svh"

module quadratic_root_solver #(
  parameter int COEF_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COEF_WIDTH-1:0]  coef_a_i,
  input  logic signed [COEF_WIDTH-1:0]  coef_b_i,
  input  logic signed [COEF_WIDTH-1:0]  coef_c_i,
  output logic                          result_valid_o,
  output logic [1:0]                    root_kind_o,
  output logic signed [qrs_pkg::OUT_W-1:0] first_value_o,
  output logic signed [qrs_pkg::OUT_W-1:0] second_value_o,
  output logic                          saturated_o
);

  localparam int CW  = COEF_WIDTH;
  localparam int SW  = CW + 1;
  localparam int NW  = CW + 3;
  localparam int QW  = NW + qrs_pkg::OUT_FRAC;
  localparam int OW  = qrs_pkg::OUT_W;
  localparam int XW  = QW + OW + 1;
  localparam int LAT = 2 * CW + 26;

  assign busy_o = 1'b0;

  qrs_pkg::ctrl_t       dc_ctrl;
  logic [2*CW:0]        dc_disc;
  logic signed [CW-1:0] dc_a, dc_b;

  qrs_disc #(.CW(CW)) u_disc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start_i & ~busy_o),
    .coef_a_i (coef_a_i),
    .coef_b_i (coef_b_i),
    .coef_c_i (coef_c_i),
    .ctrl_o   (dc_ctrl),
    .disc_o   (dc_disc),
    .a_o      (dc_a),
    .b_o      (dc_b)
  );

  qrs_pkg::ctrl_t       sq_ctrl;
  logic [SW-1:0]        sq_root;
  logic signed [CW-1:0] sq_a, sq_b;

  qrs_sqrt #(.CW(CW)) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (dc_ctrl),
    .disc_i (dc_disc),
    .a_i    (dc_a),
    .b_i    (dc_b),
    .ctrl_o (sq_ctrl),
    .root_o (sq_root),
    .a_o    (sq_a),
    .b_o    (sq_b)
  );

  // numerator stage
  logic signed [NW-1:0] nb, ss, n1_d, n2_d;

  always_comb begin
    nb = -{{(NW-CW){sq_b[CW-1]}}, sq_b};
    ss = {{(NW-SW){1'b0}}, sq_root};
    case (sq_ctrl.kind)
      qrs_pkg::KIND_TWO: begin
        n1_d = nb + ss;
        n2_d = nb - ss;
      end
      qrs_pkg::KIND_CPLX: begin
        n1_d = nb;
        n2_d = ss;
      end
      default: begin
        n1_d = nb;
        n2_d = nb;
      end
    endcase
  end

  qrs_pkg::ctrl_t       nm_ctrl_q;
  logic signed [NW-1:0] n1_q, n2_q;
  logic signed [CW:0]   den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nm_ctrl_q <= '0;
    end else begin
      nm_ctrl_q <= sq_ctrl;
    end
  end

  always_ff @(posedge clk_i) begin
    n1_q  <= n1_d;
    n2_q  <= n2_d;
    den_q <= {sq_a, 1'b0};
  end

  qrs_pkg::ctrl_t dv_ctrl;
  logic [QW-1:0]  quo1, quo2;
  logic           neg1, neg2;

  qrs_div #(.CW(CW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (nm_ctrl_q),
    .num1_i (n1_q),
    .num2_i (n2_q),
    .den_i  (den_q),
    .ctrl_o (dv_ctrl),
    .quo1_o (quo1),
    .quo2_o (quo2),
    .neg1_o (neg1),
    .neg2_o (neg2)
  );

  // clamp to signed 32 bits and apply the sign; returns {sat, value}
  function automatic logic [OW:0] clamp_fn(input logic [QW-1:0] q, input logic neg);
    logic [XW-1:0] qx;
    logic          hi_any, sat;
    logic [OW-1:0] val;
    qx     = {{(OW+1){1'b0}}, q};
    hi_any = (qx[XW-1:OW] != '0);
    if (!neg) begin
      sat = hi_any || qx[OW-1];
      val = sat ? {1'b0, {(OW-1){1'b1}}} : qx[OW-1:0];
    end else begin
      sat = hi_any || (qx[OW-1] && (qx[OW-2:0] != '0));
      val = sat ? {1'b1, {(OW-1){1'b0}}} : -qx[OW-1:0];
    end
    return {sat, val};
  endfunction

  logic [OW:0] c1, c2;

  assign c1 = clamp_fn(quo1, neg1);
  assign c2 = clamp_fn(quo2, neg2);

  logic          out_v_q, sat_q;
  logic [1:0]    kind_q;
  logic [OW-1:0] v1_q, v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= dv_ctrl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= dv_ctrl.kind;
    if (dv_ctrl.kind == qrs_pkg::KIND_INVALID) begin
      v1_q  <= '0;
      v2_q  <= '0;
      sat_q <= 1'b0;
    end else begin
      v1_q  <= c1[OW-1:0];
      v2_q  <= c2[OW-1:0];
      sat_q <= c1[OW] | c2[OW];
    end
  end

  assign result_valid_o = out_v_q;
  assign root_kind_o    = kind_q;
  assign first_value_o  = v1_q;
  assign second_value_o = v2_q;
  assign saturated_o    = sat_q;

  `QRS_IMPLIES(a_latency, result_valid_o, $past(start_i, LAT))
  `QRS_IMPLIES(a_invalid_zero, result_valid_o && (root_kind_o == qrs_pkg::KIND_INVALID), (first_value_o == '0) && (second_value_o == '0) && !saturated_o)
  `QRS_IMPLIES(a_repeated_same, result_valid_o && (root_kind_o == qrs_pkg::KIND_ONE), first_value_o == second_value_o)
  `QRS_IMPLIES(a_sat_bound, result_valid_o && saturated_o, (first_value_o == 32'sh7FFFFFFF) || (first_value_o == 32'sh80000000) || (second_value_o == 32'sh7FFFFFFF) || (second_value_o == 32'sh80000000))

endmodule

### sim/root_checker.sv
module root_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic signed [15:0]  coef_a_i,
  input  logic signed [15:0]  coef_b_i,
  input  logic signed [15:0]  coef_c_i,
  input  logic                result_valid_i,
  input  logic [1:0]          root_kind_i,
  input  logic signed [31:0]  first_value_i,
  input  logic signed [31:0]  second_value_i,
  input  logic                saturated_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  checked_o,
  output int                  kind_seen_o [4],
  output int                  sat_seen_o
);

  typedef struct {
    qrs_pkg::root_kind_e kind;
    logic signed [31:0]  first;
    logic signed [31:0]  second;
    logic                sat;
  } roots_t;

  roots_t expected_roots[$];

  initial begin
    errors_o = 0;
    checked_o = 0;
    sat_seen_o = 0;
    foreach (kind_seen_o[i]) kind_seen_o[i] = 0;
  end

  assign pending_o = expected_roots.size();

  // trunc(num * 2^16 / den), clamped to signed 32 bits
  function automatic logic signed [31:0] scaled_quot(longint num, longint den,
                                                     inout logic sat);
    bit      neg;
    longint  q;
    neg = (num < 0) != (den < 0);
    q = ((num < 0 ? -num : num) <<< qrs_pkg::OUT_FRAC) / (den < 0 ? -den : den);
    if (!neg) begin
      if (q > 64'sh7FFF_FFFF) begin
        sat = 1'b1;
        q = 64'sh7FFF_FFFF;
      end
      return q[31:0];
    end
    if (q > 64'sh8000_0000) begin
      sat = 1'b1;
      q = 64'sh8000_0000;
    end
    q = -q;
    return q[31:0];
  endfunction

  function automatic longint floor_sqrt(longint v);
    longint r;
    longint t;
    r = 0;
    for (int i = 20; i >= 0; i--) begin
      t = r | (64'sd1 << i);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic roots_t solve_roots(logic signed [15:0] a, logic signed [15:0] b,
                                         logic signed [15:0] c);
    roots_t  r;
    longint  sa, sb, sc, disc, s, den;
    logic    sat;
    sa = a;
    sb = b;
    sc = c;
    sat = 1'b0;
    r.kind = qrs_pkg::KIND_INVALID;
    r.first = '0;
    r.second = '0;
    if (sa != 0) begin
      disc = sb * sb - 4 * sa * sc;
      den = 2 * sa;
      if (disc > 0) begin
        s = floor_sqrt(disc);
        r.kind = qrs_pkg::KIND_TWO;
        r.first = scaled_quot(-sb + s, den, sat);
        r.second = scaled_quot(-sb - s, den, sat);
      end else if (disc == 0) begin
        r.kind = qrs_pkg::KIND_ONE;
        r.first = scaled_quot(-sb, den, sat);
        r.second = r.first;
      end else begin
        s = floor_sqrt(-disc);
        r.kind = qrs_pkg::KIND_CPLX;
        r.first = scaled_quot(-sb, den, sat);
        r.second = scaled_quot(s, den, sat);
      end
    end
    r.sat = sat;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i) begin
    roots_t want;
    if (rst_ni) begin
      if (start_i && !busy_i)
        expected_roots.push_back(solve_roots(coef_a_i, coef_b_i, coef_c_i));
      if (result_valid_i) begin
        if (expected_roots.size() == 0) begin
          report_mismatch("unexpected transaction, kind", root_kind_i, -1);
        end else begin
          want = expected_roots.pop_front();
          checked_o++;
          kind_seen_o[want.kind]++;
          if (want.sat) sat_seen_o++;
          if (root_kind_i !== want.kind) report_mismatch("root_kind", root_kind_i, want.kind);
          if (first_value_i !== want.first)
            report_mismatch("first_value", first_value_i, want.first);
          if (second_value_i !== want.second)
            report_mismatch("second_value", second_value_i, want.second);
          if (saturated_i !== want.sat) report_mismatch("saturated", saturated_i, want.sat);
        end
      end
    end
  end
endmodule

### sim/tb_top.sv
module tb_top;
  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic signed [15:0] coef_a_i;
  logic signed [15:0] coef_b_i;
  logic signed [15:0] coef_c_i;
  logic               result_valid_o;
  logic [1:0]         root_kind_o;
  logic signed [31:0] first_value_o;
  logic signed [31:0] second_value_o;
  logic               saturated_o;
  int                 errors;
  int                 pending;
  int                 checked;
  int                 kind_seen [4];
  int                 sat_seen;
  int                 burst_left;

  quadratic_root_solver dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .coef_a_i, .coef_b_i, .coef_c_i,
    .result_valid_o, .root_kind_o, .first_value_o, .second_value_o, .saturated_o
  );

  root_checker checker_inst (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .coef_a_i, .coef_b_i, .coef_c_i,
    .result_valid_i(result_valid_o), .root_kind_i(root_kind_o),
    .first_value_i(first_value_o), .second_value_i(second_value_o),
    .saturated_i(saturated_o), .errors_o(errors), .pending_o(pending),
    .checked_o(checked), .kind_seen_o(kind_seen), .sat_seen_o(sat_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting for results");
    $display("tb_top NOT OK");
    $finish;
  end

  // called at a rising edge; returns at the edge that accepts the transaction, or after the pacing gap
  task automatic send_coefs(logic signed [15:0] a, logic signed [15:0] b,
                            logic signed [15:0] c);
    start_i <= 1'b1;
    coef_a_i <= a;
    coef_b_i <= b;
    coef_c_i <= c;
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    // burst/gap pacing
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 2) != 0) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_random;
    logic signed [15:0] a, b, c, k;
    a = 16'($urandom);
    b = 16'($urandom);
    c = 16'($urandom);
    case ($urandom_range(0, 9))
      0: a = '0;
      1: a = 16'($urandom_range(0, 7)) - 16'sd4;  // tiny a drives the roots into clamping
      2: begin  // perfect square: repeated root
        k = 16'($urandom_range(0, 255)) - 16'sd128;
        a = 16'($urandom_range(1, 200));
        if ($urandom_range(0, 1) != 0) a = -a;
        b = 16'(2 * a * k);
        c = 16'(a * k * k);
        if (b / 2 / a != k || c / a != k * k) b = '0;
        if (b == 0) c = 0;
      end
      3: begin  // small magnitudes
        a = 16'($urandom_range(0, 2047)) - 16'sd1024;
        b = 16'($urandom_range(0, 2047)) - 16'sd1024;
        c = 16'($urandom_range(0, 2047)) - 16'sd1024;
      end
      default: ;
    endcase
    send_coefs(a, b, c);
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    coef_a_i = '0;
    coef_b_i = '0;
    coef_c_i = '0;
    burst_left = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    send_coefs(16'sd0, 16'sd256, 16'sd256);            // zero a
    send_coefs(16'sd0, 16'sh8000, 16'sd32767);
    send_coefs(16'sd256, 16'sd512, 16'sd256);          // repeated root
    send_coefs(-16'sd256, 16'sd512, -16'sd256);
    send_coefs(16'sd256, 16'sd0, -16'sd1024);          // two real roots
    send_coefs(16'sd256, 16'sd0, 16'sd1024);           // complex pair
    send_coefs(-16'sd256, 16'sd256, 16'sd1024);        // two real roots, negative a
    send_coefs(16'sd1, 16'sh8000, 16'sd0);             // clamped high
    send_coefs(16'sd1, 16'sd32767, 16'sd0);            // large negative root, within range
    send_coefs(-16'sd1, 16'sd0, 16'sh8000);            // huge imaginary part
    send_coefs(16'sd32767, 16'sd32767, 16'sd32767);
    send_coefs(16'sh8000, 16'sh8000, 16'sh8000);
    send_coefs(16'sh8000, 16'sd32767, 16'sd32767);
    send_coefs(16'sd32767, 16'sh8000, 16'sh8000);
    send_coefs(16'sd1, 16'sd1, 16'sd1);
    send_coefs(-16'sd1, -16'sd1, -16'sd1);
    send_coefs(16'sd1, 16'sd0, 16'sd0);
    send_coefs(16'sd0, 16'sd0, 16'sd0);
    send_coefs(16'sd1, 16'sd2, 16'sd1);

    repeat (1850) send_random();
    start_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);

    $display("checked %0d results: %0d two real, %0d repeated, %0d complex, %0d invalid",
             checked, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
    $display("%0d results clamped to the Q16.16 range", sat_seen);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
